>>> hw/rtl/ssid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssid_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_DEFER   = 3'd2,
    OP_QUERY   = 3'd3,
    OP_FLUSH   = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CR, S_LOOK, S_CHK, S_RM1, S_RM2, S_FRD, S_FPEND, S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [10:0] entity_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] new_id;
    logic        is_live;
    logic [10:0] flushed_count;
    logic [10:0] live_count;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/ssid_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ssid_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sparse_set_id_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// One request is in work at a time, limited by the memory reads; a request is accepted
// only in the idle state, and its result is registered before the next one is taken.
// Flush walks IDs 1..MAX_IDS in ascending order and destroys each live ID with a pending mark.
// Clear, and every reset, runs a sweep over addresses 0..MAX_IDS of the sparse map and pending
// bitmap; no request is accepted during the sweep. Reset is synchronous and active high.

module sparse_set_id_allocator
  import ssid_pkg::*;
#(
  parameter int MAX_IDS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  // IW covers IDs 0..MAX_IDS; DW addresses the dense list and the free stack.
  localparam int IW = $clog2(MAX_IDS + 1);
  localparam int DW = $clog2(MAX_IDS);
  localparam logic [IW-1:0] NO_INDEX = IW'(MAX_IDS);

  state_t state, state_next;

  // Sequencer registers.
  op_t             op_r;
  logic [IW-1:0]   tgt;
  logic [IW-1:0]   idx_r;
  logic [IW-1:0]   clr_addr;
  logic            clr_reply;
  logic [1:0]      r_status;
  logic [IW-1:0]   r_new;
  logic            r_live;
  logic [IW-1:0]   flush_cnt;
  logic [IW-1:0]   alive_total;
  logic [IW-1:0]   free_depth;
  logic [IW:0]     fresh_next;

  // Memory ports.
  logic          smap_we, smap_re;
  logic [IW-1:0] smap_waddr, smap_raddr, smap_wdata, smap_q;
  logic          pend_we, pend_re;
  logic [IW-1:0] pend_waddr, pend_raddr;
  logic          pend_wdata, pend_q;
  logic          dense_we, dense_re;
  logic [DW-1:0] dense_waddr, dense_raddr;
  logic [IW-1:0] dense_wdata, dense_q;
  logic          fstk_we, fstk_re;
  logic [DW-1:0] fstk_waddr, fstk_raddr;
  logic [IW-1:0] fstk_wdata, fstk_q;

  ssid_ram #(.WIDTH(IW), .DEPTH(MAX_IDS + 1)) u_smap (
    .clk, .we(smap_we), .waddr(smap_waddr), .wdata(smap_wdata),
    .re(smap_re), .raddr(smap_raddr), .rdata(smap_q)
  );
  ssid_ram #(.WIDTH(1), .DEPTH(MAX_IDS + 1)) u_pend (
    .clk, .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .re(pend_re), .raddr(pend_raddr), .rdata(pend_q)
  );
  ssid_ram #(.WIDTH(IW), .DEPTH(MAX_IDS)) u_dense (
    .clk, .we(dense_we), .waddr(dense_waddr), .wdata(dense_wdata),
    .re(dense_re), .raddr(dense_raddr), .rdata(dense_q)
  );
  ssid_ram #(.WIDTH(IW), .DEPTH(MAX_IDS)) u_fstk (
    .clk, .we(fstk_we), .waddr(fstk_waddr), .wdata(fstk_wdata),
    .re(fstk_re), .raddr(fstk_raddr), .rdata(fstk_q)
  );

  // Decode of the incoming request.
  logic          req_fire;
  logic [IW-1:0] req_id;
  logic          req_id_ok;
  logic          req_ignored;
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign req_id    = IW'(req.entity_id);
  assign req_id_ok = (req.entity_id != 11'd0) && (32'(req.entity_id) <= MAX_IDS);
  // Destroy and deferred destroy on an out-of-range ID, and unused codes, are ignored.
  assign req_ignored = (((op_t'(req.operation) == OP_DESTROY) ||
                         (op_t'(req.operation) == OP_DEFER)) && !req_id_ok) ||
                       (op_t'(req.operation) == OP_RSVD6) ||
                       (op_t'(req.operation) == OP_RSVD7);

  // Create: a freed ID is preferred over a fresh one.
  logic          have_free, have_fresh, cr_ok;
  logic [IW-1:0] cr_id;
  assign have_free  = (free_depth != '0);
  assign have_fresh = (32'(fresh_next) <= MAX_IDS);
  assign cr_id      = have_free ? fstk_q : fresh_next[IW-1:0];
  assign cr_ok      = (have_free || have_fresh) && (32'(alive_total) < MAX_IDS);

  // Liveness: the mapped index must lie in the dense part and point back at the ID.
  logic hit;
  assign hit = (idx_r < alive_total) && (dense_q == tgt);

  logic last_id;
  assign last_id = (tgt == NO_INDEX);

  logic res_free;
  assign res_free = !res_valid || res_ready;

  always_comb begin
    state_next  = state;
    smap_we     = 1'b0;
    smap_waddr  = '0;
    smap_wdata  = '0;
    smap_re     = 1'b0;
    smap_raddr  = '0;
    pend_we     = 1'b0;
    pend_waddr  = '0;
    pend_wdata  = 1'b0;
    pend_re     = 1'b0;
    pend_raddr  = '0;
    dense_we    = 1'b0;
    dense_waddr = '0;
    dense_wdata = '0;
    dense_re    = 1'b0;
    dense_raddr = '0;
    fstk_we     = 1'b0;
    fstk_waddr  = '0;
    fstk_wdata  = '0;
    fstk_re     = 1'b0;
    fstk_raddr  = '0;
    unique case (state)
      S_CLR: begin
        smap_we    = 1'b1;
        smap_waddr = clr_addr;
        smap_wdata = NO_INDEX;
        pend_we    = 1'b1;
        pend_waddr = clr_addr;
        if (clr_addr == NO_INDEX) begin
          state_next = clr_reply ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          unique case (op_t'(req.operation))
            OP_CREATE: begin
              fstk_re    = 1'b1;
              fstk_raddr = DW'(free_depth - 1'b1);
              state_next = S_CR;
            end
            OP_DESTROY, OP_DEFER, OP_QUERY: begin
              if (req_id_ok) begin
                smap_re    = 1'b1;
                smap_raddr = req_id;
                state_next = S_LOOK;
              end else begin
                state_next = S_FIN;
              end
            end
            OP_FLUSH: state_next = S_FRD;
            OP_CLEAR: state_next = S_CLR;
            default:  state_next = S_FIN;
          endcase
        end
      end
      S_CR: begin
        if (cr_ok) begin
          smap_we     = 1'b1;
          smap_waddr  = cr_id;
          smap_wdata  = alive_total;
          dense_we    = 1'b1;
          dense_waddr = DW'(alive_total);
          dense_wdata = cr_id;
        end
        state_next = S_FIN;
      end
      S_LOOK: begin
        dense_re    = 1'b1;
        dense_raddr = DW'(smap_q);
        state_next  = S_CHK;
      end
      S_CHK: begin
        priority case (op_r)
          OP_QUERY: state_next = S_FIN;
          OP_DEFER: begin
            pend_we    = hit;
            pend_waddr = tgt;
            pend_wdata = 1'b1;
            state_next = S_FIN;
          end
          default: begin
            if (hit) begin
              // Fetch the last dense entry, which fills the hole.
              dense_re    = 1'b1;
              dense_raddr = DW'(alive_total - 1'b1);
              state_next  = S_RM1;
            end else if (op_r == OP_FLUSH) begin
              state_next = last_id ? S_FIN : S_FRD;
            end else begin
              state_next = S_FIN;
            end
          end
        endcase
      end
      S_RM1: begin
        dense_we    = 1'b1;
        dense_waddr = DW'(idx_r);
        dense_wdata = dense_q;
        smap_we     = 1'b1;
        smap_waddr  = dense_q;
        smap_wdata  = idx_r;
        state_next  = S_RM2;
      end
      S_RM2: begin
        // Written after the moved entry so that removing the last entry ends unmapped.
        smap_we    = 1'b1;
        smap_waddr = tgt;
        smap_wdata = NO_INDEX;
        if (32'(free_depth) < MAX_IDS) begin
          fstk_we    = 1'b1;
          fstk_waddr = DW'(free_depth);
          fstk_wdata = tgt;
        end
        if (op_r == OP_FLUSH && !last_id) begin
          state_next = S_FRD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FRD: begin
        pend_re    = 1'b1;
        pend_raddr = tgt;
        smap_re    = 1'b1;
        smap_raddr = tgt;
        state_next = S_FPEND;
      end
      S_FPEND: begin
        pend_we    = 1'b1;
        pend_waddr = tgt;
        if (pend_q) begin
          dense_re    = 1'b1;
          dense_raddr = DW'(smap_q);
          state_next  = S_CHK;
        end else begin
          state_next = last_id ? S_FIN : S_FRD;
        end
      end
      S_FIN: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      alive_total <= '0;
      free_depth  <= '0;
      fresh_next  <= (IW + 1)'(1);
      res_valid   <= 1'b0;
    end else begin
      // In the result state a free output register takes the new result instead.
      if (res_valid && res_ready && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (req_fire) begin
            op_r      <= op_t'(req.operation);
            tgt       <= (op_t'(req.operation) == OP_FLUSH) ? IW'(1) : req_id;
            r_status  <= req_ignored ? ST_IGNORED : ST_DONE;
            r_new     <= '0;
            r_live    <= 1'b0;
            flush_cnt <= '0;
            if (op_t'(req.operation) == OP_CLEAR) begin
              clr_addr    <= '0;
              clr_reply   <= 1'b1;
              alive_total <= '0;
              free_depth  <= '0;
              fresh_next  <= (IW + 1)'(1);
            end
          end
        end
        S_CR: begin
          if (have_free) begin
            free_depth <= free_depth - 1'b1;
            r_new      <= fstk_q;
          end else if (have_fresh) begin
            fresh_next <= fresh_next + 1'b1;
            r_new      <= fresh_next[IW-1:0];
          end else begin
            r_status <= ST_FULL;
          end
          if (cr_ok) begin
            alive_total <= alive_total + 1'b1;
          end
        end
        S_LOOK: begin
          idx_r <= smap_q;
        end
        S_CHK: begin
          if (op_r == OP_QUERY) begin
            r_live <= hit;
          end else if (op_r == OP_FLUSH) begin
            if (!hit && !last_id) begin
              tgt <= tgt + 1'b1;
            end
          end else if (!hit) begin
            r_status <= ST_IGNORED;
          end
        end
        S_RM1: begin
          alive_total <= alive_total - 1'b1;
        end
        S_RM2: begin
          if (32'(free_depth) < MAX_IDS) begin
            free_depth <= free_depth + 1'b1;
          end
          if (op_r == OP_FLUSH) begin
            flush_cnt <= flush_cnt + 1'b1;
            if (!last_id) begin
              tgt <= tgt + 1'b1;
            end
          end
        end
        S_FRD: ;
        S_FPEND: begin
          idx_r <= smap_q;
          if (!pend_q && !last_id) begin
            tgt <= tgt + 1'b1;
          end
        end
        S_FIN: begin
          if (res_free) begin
            res.status        <= r_status;
            res.new_id        <= 11'(r_new);
            res.is_live       <= r_live;
            res.flushed_count <= 11'(flush_cnt);
            res.live_count    <= 11'(alive_total);
            res_valid         <= 1'b1;
            clr_reply         <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Every ID is either alive or on the free stack at most once.
  a_id_budget: assert property (@(posedge clk) disable iff (rst)
    (32'(alive_total) + 32'(free_depth)) <= MAX_IDS)
    else $error("alive plus freed IDs exceed MAX_IDS");

  // The second removal write always follows the first.
  a_rm_order: assert property (@(posedge clk) disable iff (rst)
    state == S_RM2 |-> $past(state) == S_RM1)
    else $error("removal sequence out of order");

  // A request is taken only while no removal or sweep is under way.
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    req_fire |-> !smap_we && !dense_we && !fstk_we)
    else $error("request accepted during a memory update");

  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    32'(fresh_next) <= MAX_IDS + 1)
    else $error("fresh ID counter out of range");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench
  import ssid_pkg::*;
();

  localparam int MAX_IDS = 1024;
  localparam int NO_INDEX = MAX_IDS;
  // The run fails once nothing moves on either channel for this many cycles. A flush
  // walks all IDs, and the receiver may stall on top.
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  sparse_set_id_allocator #(.MAX_IDS(MAX_IDS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  // Our own copy of the allocator state, updated once per accepted request.
  int sparse_idx [0:MAX_IDS];
  int dense_ids [0:MAX_IDS-1];
  int free_ids [0:MAX_IDS-1];
  bit marked [0:MAX_IDS];
  int free_top;
  int live_total;
  int next_fresh;

  res_t expected_results[$];
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void wipe_allocator();
    for (int i = 0; i <= MAX_IDS; i++) begin
      sparse_idx[i] = NO_INDEX;
      marked[i] = 1'b0;
    end
    free_top = 0;
    live_total = 0;
    next_fresh = 1;
  endfunction

  function automatic bit id_is_live(int id);
    int idx;
    if (id == 0 || id > MAX_IDS) return 1'b0;
    idx = sparse_idx[id];
    if (idx == NO_INDEX || idx >= live_total) return 1'b0;
    return dense_ids[idx] == id;
  endfunction

  // Swap-remove from the dense list, then push the ID on the free stack.
  function automatic void retire_id(int id);
    int hole;
    int last;
    hole = sparse_idx[id];
    last = dense_ids[live_total - 1];
    dense_ids[hole] = last;
    sparse_idx[last] = hole;
    live_total--;
    sparse_idx[id] = NO_INDEX;
    if (free_top < MAX_IDS) begin
      free_ids[free_top] = id;
      free_top++;
    end
  endfunction

  function automatic res_t allocate_response(req_t r);
    res_t o;
    int id;
    int flushed;
    o = '0;
    o.status = ST_DONE;
    id = int'(r.entity_id);
    flushed = 0;
    case (op_t'(r.operation))
      OP_CREATE: begin
        if (free_top > 0) begin
          free_top--;
          o.new_id = 11'(free_ids[free_top]);
        end else if (next_fresh <= MAX_IDS) begin
          o.new_id = 11'(next_fresh);
          next_fresh++;
        end else begin
          o.status = ST_FULL;
        end
        if (o.status == ST_DONE && live_total < MAX_IDS) begin
          sparse_idx[o.new_id] = live_total;
          dense_ids[live_total] = int'(o.new_id);
          live_total++;
        end
      end
      OP_DESTROY: begin
        if (id_is_live(id)) retire_id(id);
        else o.status = ST_IGNORED;
      end
      OP_DEFER: begin
        if (id_is_live(id)) marked[id] = 1'b1;
        else o.status = ST_IGNORED;
      end
      OP_QUERY: o.is_live = id_is_live(id);
      OP_FLUSH: begin
        // Ascending walk; a stale mark on a dead ID is simply skipped.
        for (int i = 1; i <= MAX_IDS; i++) begin
          if (marked[i] && id_is_live(i)) begin
            retire_id(i);
            flushed++;
          end
          marked[i] = 1'b0;
        end
        o.flushed_count = 11'(flushed);
      end
      OP_CLEAR: wipe_allocator();
      default: o.status = ST_IGNORED;
    endcase
    o.live_count = 11'(live_total);
    return o;
  endfunction

  // Sends one request and records its expected response at acceptance.
  // The block never takes two requests on neighboring edges, so the cycle
  // with valid low after each acceptance costs nothing.
  task automatic send_request(op_t op, logic [10:0] id);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req_valid <= 1'b1;
    req <= '{operation: op, entity_id: id};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_results = {expected_results, allocate_response('{operation: op, entity_id: id})};
    req_valid <= 1'b0;
  endtask

  // The receiver side: random stalls, and every response compared with the
  // oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: response with nothing expected: %p", $time, res);
          error_count++;
        end else begin
          res_t want;
          want = expected_results.pop_front();
          if (res.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, res.status);
            error_count++;
          end
          if (res.new_id !== want.new_id) begin
            $display("%0t: new_id expected %0d actual %0d", $time, want.new_id, res.new_id);
            error_count++;
          end
          if (res.is_live !== want.is_live) begin
            $display("%0t: is_live expected %0d actual %0d", $time, want.is_live,
                     res.is_live);
            error_count++;
          end
          if (res.flushed_count !== want.flushed_count) begin
            $display("%0t: flushed_count expected %0d actual %0d", $time,
                     want.flushed_count, res.flushed_count);
            error_count++;
          end
          if (res.live_count !== want.live_count) begin
            $display("%0t: live_count expected %0d actual %0d", $time,
                     want.live_count, res.live_count);
            error_count++;
          end
        end
      end
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_for_drain();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random target: mostly IDs that are likely alive, sometimes edge values.
  function automatic logic [10:0] pick_target();
    int k;
    k = $urandom_range(99);
    if (k < 70 && live_total > 0) return 11'(dense_ids[$urandom_range(live_total - 1)]);
    if (k < 80) return 11'($urandom_range(next_fresh > 1 ? next_fresh : 1));
    if (k < 85) return 11'd0;
    if (k < 90) return 11'($urandom_range(2047, MAX_IDS + 1));
    return 11'($urandom_range(2047));
  endfunction

  // Extremes of the ID field, every operation, invalid and dead targets.
  task automatic test_directed();
    send_request(OP_QUERY, 11'd0);
    send_request(OP_DESTROY, 11'd0);
    send_request(OP_DEFER, 11'd2047);
    send_request(OP_FLUSH, 11'd0);
    send_request(OP_CREATE, 11'd0);
    send_request(OP_CREATE, 11'd2047);
    send_request(OP_CREATE, 11'd0);
    send_request(OP_QUERY, 11'd1);
    send_request(OP_QUERY, 11'd1024);
    send_request(OP_QUERY, 11'd1025);
    send_request(OP_DESTROY, 11'd1);
    send_request(OP_DESTROY, 11'd1);
    send_request(OP_DEFER, 11'd2);
    send_request(OP_DEFER, 11'd3);
    // A stale mark: ID 3 dies and is reissued, so the flush hits the new holder.
    send_request(OP_DESTROY, 11'd3);
    send_request(OP_CREATE, 11'd0);
    send_request(OP_FLUSH, 11'd0);
    send_request(op_t'(OP_RSVD6), 11'd5);
    send_request(op_t'(OP_RSVD7), 11'd2047);
    send_request(OP_CLEAR, 11'd0);
    send_request(OP_QUERY, 11'd2);
  endtask

  // Use up every ID, check the full response, then recycle through the stack.
  task automatic test_exhaustion();
    for (int i = 0; i < MAX_IDS + 2; i++) send_request(OP_CREATE, 11'($urandom));
    send_request(OP_QUERY, 11'd1024);
    send_request(OP_DESTROY, 11'd1024);
    send_request(OP_DESTROY, 11'd7);
    send_request(OP_CREATE, 11'd0);
    send_request(OP_CREATE, 11'd0);
    send_request(OP_DEFER, 11'd1024);
    send_request(OP_FLUSH, 11'd0);
    send_request(OP_CLEAR, 11'd0);
  endtask

  // Mostly create, destroy, defer and query on likely live IDs, with flush, clear and unused codes now and then.
  task automatic test_random(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(999);
      if (k < 330) send_request(OP_CREATE, 11'($urandom));
      else if (k < 560) send_request(OP_DESTROY, pick_target());
      else if (k < 760) send_request(OP_DEFER, pick_target());
      else if (k < 950) send_request(OP_QUERY, pick_target());
      else if (k < 975) send_request(OP_FLUSH, 11'($urandom));
      else if (k < 980) send_request(OP_CLEAR, 11'($urandom));
      else send_request(op_t'($urandom_range(7, 6)), 11'($urandom));
      if (n == count / 2) wait_for_drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    res_ready = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wipe_allocator();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_exhaustion();
    test_random(250);
    send_idle_pct = 79;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    test_random(150);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    test_random(150);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_for_drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ssid_pkg.sv
hw/rtl/ssid_ram.sv
hw/rtl/sparse_set_id_allocator.sv
sim/testbench.sv
